@@ rtl/ordered_list_engine_macros.svh @@
// Assertion macros used by the checker of the ordered list engine.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define OLE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication, disabled while reset is active
`define OLE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

@@ rtl/ole_pkg.sv @@
// Package of the ordered list engine: sizes, codes and the cell control word.
package ole_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned STAT_W = 2;
  // width that holds both a position and a count plus one
  localparam int unsigned CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEDUPE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_EVEN   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd6;
  localparam logic [FUNC_W-1:0] FN_DUMP   = 3'd7;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROT,   // segment [0, seg-1] rotates toward cell 0, feed enters at seg-1
    CELL_SHR    // cell pos takes feed, cells pos+1..seg take their left neighbor
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic                cmp;   // latch key match inside [lo, seg-1]
    logic [CNT_W-1:0]    seg;
    logic [CNT_W-1:0]    pos;
    logic [CNT_W-1:0]    lo;
    logic [DATA_W-1:0]   feed;
    logic [DATA_W-1:0]   key;
  } cell_ctl_t;

endpackage

@@ rtl/ole_if.sv @@
// Handshake channels of the ordered list engine: request and result words.
interface ole_in_if;
  logic                             valid;
  logic                             ready;
  logic [ole_pkg::FUNC_W-1:0]       func;
  logic [ole_pkg::POS_W-1:0]        position;
  logic signed [ole_pkg::DATA_W-1:0] value;

  modport source (output valid, func, position, value, input ready);
  modport sink   (input valid, func, position, value, output ready);
endinterface

interface ole_out_if;
  logic                              valid;
  logic                              ready;
  logic [ole_pkg::STAT_W-1:0]        status;
  logic [ole_pkg::POS_W-1:0]         found_position;
  logic signed [ole_pkg::DATA_W-1:0] data_out;
  logic                              last;

  modport source (output valid, status, found_position, data_out, last, input ready);
  modport sink   (input valid, status, found_position, data_out, last, output ready);
endinterface

@@ rtl/ole_cell.sv @@
// One list cell: holds an entry, shifts with its neighbors, compares to a key.
module ole_cell (
  input  logic                         clk_i,
  input  logic [ole_pkg::CNT_W-1:0]    idx_i,
  input  ole_pkg::cell_ctl_t           ctl_i,
  input  logic [ole_pkg::DATA_W-1:0]   left_i,
  input  logic [ole_pkg::DATA_W-1:0]   right_i,
  output logic [ole_pkg::DATA_W-1:0]   data_o,
  output logic                         match_o
);

  logic [ole_pkg::DATA_W-1:0] data_q, data_d;
  logic                       match_q, match_d;
  logic [ole_pkg::CNT_W-1:0]  idx_nxt;

  assign idx_nxt = idx_i + ole_pkg::CNT_W'(1);

  // next entry value
  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      ole_pkg::CELL_ROT: begin
        if (idx_nxt < ctl_i.seg) begin
          data_d = right_i;
        end else if (idx_nxt == ctl_i.seg) begin
          data_d = ctl_i.feed;
        end
      end
      ole_pkg::CELL_SHR: begin
        if (idx_i == ctl_i.pos) begin
          data_d = ctl_i.feed;
        end else if ((idx_i > ctl_i.pos) && (idx_i <= ctl_i.seg)) begin
          data_d = left_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // key match, only for cells inside the kept range
  always_comb begin
    match_d = match_q;
    if (ctl_i.cmp) begin
      match_d = (idx_i >= ctl_i.lo) && (idx_i < ctl_i.seg) && (data_q == ctl_i.key);
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    match_q <= match_d;
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

@@ rtl/ole_seq.sv @@
// Sequencer: decodes an operation, steers the cell chain, builds result words.
module ole_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ole_in_if.sink                     in_i,
  ole_out_if.source                  out_o,
  input  logic [ole_pkg::DATA_W-1:0] head_i,
  input  logic                       any_match_i,
  output ole_pkg::cell_ctl_t         ctl_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_DCMP = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam int unsigned CW = ole_pkg::CNT_W;
  localparam int unsigned PW = ole_pkg::CMP_W;

  logic [2:0]                   state_q, state_d;
  logic [ole_pkg::FUNC_W-1:0]   func_q, func_d;
  logic [ole_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [ole_pkg::DATA_W-1:0]   val_q, val_d;
  logic [CW-1:0]                n_q, n_d;
  logic [CW-1:0]                m_q, m_d;
  logic [CW-1:0]                w_q, w_d;
  logic [CW-1:0]                k_q, k_d;
  logic                         hit_q, hit_d;
  logic [CW-1:0]                found_q, found_d;
  logic [ole_pkg::DATA_W-1:0]   rem_q, rem_d;

  logic                         ov_q, ov_d;
  logic [ole_pkg::STAT_W-1:0]   ostat_q, ostat_d;
  logic [ole_pkg::POS_W-1:0]    ofound_q, ofound_d;
  logic [ole_pkg::DATA_W-1:0]   odata_q, odata_d;
  logic                         olast_q, olast_d;

  logic          emit_ok;
  logic          last_step;
  logic          drop;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] n_ext;

  assign emit_ok   = !ov_q || out_o.ready;
  assign last_step = (k_q == (n_q - CW'(1)));
  assign pos_ext   = PW'(pos_q);
  assign n_ext     = PW'(n_q);

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    func_d   = func_q;
    pos_d    = pos_q;
    val_d    = val_q;
    n_d      = n_q;
    m_d      = m_q;
    w_d      = w_q;
    k_d      = k_q;
    hit_d    = hit_q;
    found_d  = found_q;
    rem_d    = rem_q;
    ov_d     = ov_q;
    ostat_d  = ostat_q;
    ofound_d = ofound_q;
    odata_d  = odata_q;
    olast_d  = olast_q;
    drop     = 1'b0;

    ctl_o.op   = ole_pkg::CELL_HOLD;
    ctl_o.cmp  = 1'b0;
    ctl_o.seg  = m_q;
    ctl_o.pos  = '0;
    ctl_o.lo   = m_q - w_q;
    ctl_o.feed = head_i;
    ctl_o.key  = head_i;

    // result word leaves
    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          func_d  = in_i.func;
          pos_d   = in_i.position;
          val_d   = in_i.value;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        if (emit_ok) begin
          // defaults for a single-word result; a walk clears ov_d again
          ov_d     = 1'b1;
          ostat_d  = ole_pkg::ST_OK;
          ofound_d = '0;
          odata_d  = '0;
          olast_d  = 1'b1;
          state_d  = S_IDLE;
          // walk setup, used when a walk starts
          k_d     = '0;
          m_d     = n_q;
          w_d     = '0;
          hit_d   = 1'b0;
          found_d = '0;
          rem_d   = '0;
          case (func_q)
            ole_pkg::FN_SEARCH: begin
              if (n_q == '0) begin
                ostat_d = ole_pkg::ST_BAD;
              end else begin
                ov_d    = ov_q && !out_o.ready;
                state_d = S_WALK;
              end
            end
            ole_pkg::FN_INSERT: begin
              if ((pos_ext == '0) || (pos_ext > (n_ext + PW'(1)))) begin
                ostat_d = ole_pkg::ST_BAD;
              end else if (n_ext == PW'(ole_pkg::DEPTH)) begin
                ostat_d = ole_pkg::ST_FULL;
              end else begin
                ctl_o.op   = ole_pkg::CELL_SHR;
                ctl_o.pos  = CW'(pos_ext - PW'(1));
                ctl_o.seg  = n_q;
                ctl_o.feed = val_q;
                n_d        = n_q + CW'(1);
              end
            end
            ole_pkg::FN_DELETE: begin
              if (n_q == '0) begin
                ostat_d = ole_pkg::ST_EMPTY;
              end else if ((pos_ext == '0) || (pos_ext > n_ext)) begin
                ostat_d = ole_pkg::ST_BAD;
              end else begin
                ov_d    = ov_q && !out_o.ready;
                state_d = S_WALK;
              end
            end
            ole_pkg::FN_DEDUPE: begin
              if (n_q != '0) begin
                ov_d    = ov_q && !out_o.ready;
                state_d = S_DCMP;
              end
            end
            ole_pkg::FN_EVEN: begin
              if (n_q != '0) begin
                ov_d    = ov_q && !out_o.ready;
                state_d = S_WALK;
              end
            end
            ole_pkg::FN_CLEAR: begin
              n_d = '0;
            end
            ole_pkg::FN_APPEND: begin
              if (n_ext == PW'(ole_pkg::DEPTH)) begin
                ostat_d = ole_pkg::ST_FULL;
              end else begin
                ctl_o.op   = ole_pkg::CELL_SHR;
                ctl_o.pos  = n_q;
                ctl_o.seg  = n_q;
                ctl_o.feed = val_q;
                n_d        = n_q + CW'(1);
              end
            end
            default: begin
              if (n_q == '0) begin
                ostat_d = ole_pkg::ST_EMPTY;
              end else begin
                ov_d    = ov_q && !out_o.ready;
                state_d = S_WALK;
              end
            end
          endcase
        end
      end

      // dedupe: cells compare the head against the kept entries
      S_DCMP: begin
        ctl_o.cmp = 1'b1;
        state_d   = S_WALK;
      end

      // one entry per cycle passes the head of the chain, unless a dump word stalls
      S_WALK: begin
        if ((func_q != ole_pkg::FN_DUMP) || emit_ok) begin
          ctl_o.op = ole_pkg::CELL_ROT;
          case (func_q)
            ole_pkg::FN_SEARCH: begin
              if (!hit_q && (head_i == val_q)) begin
                hit_d   = 1'b1;
                found_d = k_q + CW'(1);
              end
            end
            ole_pkg::FN_DELETE: begin
              drop = (PW'(k_q) == (pos_ext - PW'(1)));
              if (drop) begin
                rem_d = head_i;
              end
            end
            ole_pkg::FN_DEDUPE: drop = any_match_i;
            ole_pkg::FN_EVEN:   drop = !head_i[0];
            ole_pkg::FN_DUMP: begin
              ov_d     = 1'b1;
              ostat_d  = ole_pkg::ST_OK;
              ofound_d = '0;
              odata_d  = head_i;
              olast_d  = last_step;
            end
            default: drop = 1'b0;
          endcase
          m_d = drop ? (m_q - CW'(1)) : m_q;
          w_d = drop ? w_q : (w_q + CW'(1));
          k_d = k_q + CW'(1);
          if (last_step) begin
            n_d     = m_d;
            state_d = (func_q == ole_pkg::FN_DUMP) ? S_IDLE : S_FIN;
          end else begin
            state_d = (func_q == ole_pkg::FN_DEDUPE) ? S_DCMP : S_WALK;
          end
        end
      end

      S_FIN: begin
        if (emit_ok) begin
          ov_d     = 1'b1;
          olast_d  = 1'b1;
          ostat_d  = ole_pkg::ST_OK;
          ofound_d = '0;
          odata_d  = '0;
          if (func_q == ole_pkg::FN_SEARCH) begin
            ostat_d  = hit_q ? ole_pkg::ST_OK : ole_pkg::ST_BAD;
            ofound_d = ole_pkg::POS_W'(found_q);
          end
          if (func_q == ole_pkg::FN_DELETE) begin
            odata_d = rem_q;
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      ov_q    <= ov_d;
    end
  end

  // operands, walk bookkeeping and result payload
  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    m_q      <= m_d;
    w_q      <= w_d;
    k_q      <= k_d;
    hit_q    <= hit_d;
    found_q  <= found_d;
    rem_q    <= rem_d;
    ostat_q  <= ostat_d;
    ofound_q <= ofound_d;
    odata_q  <= odata_d;
    olast_q  <= olast_d;
  end

  assign out_o.valid          = ov_q;
  assign out_o.status         = ostat_q;
  assign out_o.found_position = ofound_q;
  assign out_o.data_out       = odata_q;
  assign out_o.last           = olast_q;

endmodule

@@ rtl/ordered_list_engine.sv @@
// Top level of the ordered list engine: sequencer plus a chain of list cells.
//
//   channel | dir | word                                  | accepted when
//   in_i    | in  | func, position, value                 | valid && ready
//   out_o   | out | status, found_position, data_out, last| valid && ready
//
// One operation at a time. Insert, append, clear and rejected operations give
// their result from the execute state; search, delete, drop-even and dedupe
// walk the list first (dedupe with a compare state per entry), and dump gives
// a word per entry; one entry per cycle passes the head cell unless stalled.
// Input is ready again once the result is issued.
// Reset empties the list; entries themselves are not cleared.
// A stalled result word holds; dump waits on out_o.ready for each entry.
module ordered_list_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  ole_in_if.sink    in_i,
  ole_out_if.source out_o
);

  ole_pkg::cell_ctl_t         ctl;
  logic [ole_pkg::DATA_W-1:0] cell_data [ole_pkg::DEPTH];
  logic [ole_pkg::DEPTH-1:0]  cell_match;

  ole_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .head_i      (cell_data[0]),
    .any_match_i (|cell_match),
    .ctl_o       (ctl)
  );

  // cell chain, cell 0 is the list head
  for (genvar g = 0; g < ole_pkg::DEPTH; g++) begin : g_cell
    logic [ole_pkg::DATA_W-1:0] left_w;
    logic [ole_pkg::DATA_W-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == ole_pkg::DEPTH - 1) begin : g_lastc
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    ole_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (ole_pkg::CNT_W'(g)),
      .ctl_i   (ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g]),
      .match_o (cell_match[g])
    );
  end

endmodule

@@ rtl/ole_checker.sv @@
// Port-level checker of the ordered list engine, bound to the top level.
`include "ordered_list_engine_macros.svh"

module ole_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [ole_pkg::STAT_W-1:0]   out_status_i,
  input logic [ole_pkg::POS_W-1:0]    out_found_i,
  input logic [ole_pkg::DATA_W-1:0]   out_data_i,
  input logic                         out_last_i
);

  // an accepted word keeps the block busy in the next cycle
  `OLE_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // only dump gives words ahead of the last one, and those are plain entries
  `OLE_ASSERT_IMP(a_mid_word_ok, clk_i, rst_ni, out_valid_i && !out_last_i, (out_status_i == ole_pkg::ST_OK) && (out_found_i == '0))

  // a found position comes only with a successful single-word search result
  `OLE_ASSERT_IMP(a_found_ok, clk_i, rst_ni, out_valid_i && (out_found_i != '0), (out_status_i == ole_pkg::ST_OK) && out_last_i && (out_data_i == '0))

  // a stalled result word holds
  `OLE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i) && $stable(out_status_i) && $stable(out_last_i))

endmodule

bind ordered_list_engine ole_checker u_ole_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_found_i  (out_o.found_position),
  .out_data_i   (out_o.data_out),
  .out_last_i   (out_o.last)
);
